[hw/rtl/uvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants for the UV sphere grid-point generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int COORD_BITS = 16;
  localparam int COORD_PB   = (COORD_BITS > 16) ? 16 : ((COORD_BITS < 2) ? 2 : COORD_BITS);
  localparam int COORD_P    = COORD_PB - 1;
  localparam int SH_XY      = 60 - COORD_P;
  localparam int SH_Z       = 30 - COORD_P;
  localparam int CODE_SHIFT = 15 - COORD_P;
  localparam logic [63:0] CODE_LIM = (64'd1 << COORD_P) - 64'd1;

  localparam logic CFG_LON = 1'b0;
  localparam logic CFG_LAT = 1'b1;

  localparam logic [7:0] LON_RST = 8'd20;
  localparam logic [7:0] LAT_RST = 8'd20;

  // divider pipeline geometry
  localparam int DIV_NW     = 24;
  localparam int DIV_DW     = 9;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = DIV_NW / DIV_BPS;

  localparam logic [26:0] SIN_C = 27'd76016977;
  localparam logic [29:0] SIN_B = 30'd688904866;
  localparam logic [30:0] SIN_A = 31'd1686629713;

  localparam int BACK_STAGES = 6;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;

  typedef struct packed {
    logic [15:0] theta;
    logic [15:0] phi;
    logic        in_range;
    logic        quad_valid;
    logic [15:0] tri0_a;
    logic [15:0] tri0_b;
    logic [15:0] tri0_c;
    logic [15:0] tri1_a;
    logic [15:0] tri1_b;
    logic [15:0] tri1_c;
  } uvs_item_t;

endpackage

[hw/rtl/uvs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, four quotient bits per stage.
// ----------------------------------------------------------------------------
module uvs_div
  import uvs_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_NW-1:0] quo,
  output logic [DIV_DW-1:0] rem
);

  logic [DIV_NW-1:0] num_r [DIV_STAGES];
  logic [DIV_NW-1:0] quo_r [DIV_STAGES];
  logic [DIV_DW-1:0] rem_r [DIV_STAGES];
  logic [DIV_DW-1:0] den_r [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DIV_NW-1:0] n_in, q_in, n_nxt, q_nxt;
    logic [DIV_DW-1:0] r_in, d_in, r_nxt;

    if (g == 0) begin : g_first
      assign n_in = num;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_rest
      assign n_in = num_r[g-1];
      assign q_in = quo_r[g-1];
      assign r_in = rem_r[g-1];
      assign d_in = den_r[g-1];
    end

    always_comb begin
      logic [DIV_DW:0]   r;
      logic [DIV_NW-1:0] nv;
      logic [DIV_NW-1:0] qv;
      r  = {1'b0, r_in};
      nv = n_in;
      qv = q_in;
      for (int b = 0; b < DIV_BPS; b++) begin
        r  = {r[DIV_DW-1:0], nv[DIV_NW-1]};
        nv = {nv[DIV_NW-2:0], 1'b0};
        qv = {qv[DIV_NW-2:0], 1'b0};
        if (r >= {1'b0, d_in}) begin
          r     = r - {1'b0, d_in};
          qv[0] = 1'b1;
        end
      end
      n_nxt = nv;
      q_nxt = qv;
      r_nxt = r[DIV_DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[g] <= n_nxt;
        quo_r[g] <= q_nxt;
        rem_r[g] <= r_nxt;
        den_r[g] <= d_in;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];
  assign rem = rem_r[DIV_STAGES-1];

endmodule

[hw/rtl/uvs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_front
// Accepts grid points, works out the angles and the quad indices.
// ----------------------------------------------------------------------------
module uvs_front
  import uvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] seg_m,
  input  logic [7:0] seg_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_lon_step,
  input  logic [7:0] in_lat_step,
  output logic       push,
  output uvs_item_t  item,
  input  logic       full
);

  logic              adv;
  logic              v_r [DIV_STAGES];
  logic [7:0]        i_r [DIV_STAGES];
  logic [7:0]        j_r [DIV_STAGES];
  logic [DIV_NW-1:0] th_q, ph_q, md_q;
  logic [DIV_DW-1:0] th_r, ph_r, md_r;
  logic [7:0]        i_l, j_l;
  logic [16:0]       row;
  logic [17:0]       cur, nb, m1;

  assign adv      = !(v_r[DIV_STAGES-1] && full);
  assign in_stall = !adv;
  assign push     = v_r[DIV_STAGES-1] && !full;

  uvs_div u_div_theta (
    .clk (clk), .en (adv),
    .num ({in_lon_step, 16'd0} + {17'd0, seg_m[7:1]}),
    .den ({1'b0, seg_m}),
    .quo (th_q), .rem (th_r)
  );

  uvs_div u_div_phi (
    .clk (clk), .en (adv),
    .num ({1'b0, in_lat_step, 15'd0} + {17'd0, seg_n[7:1]}),
    .den ({1'b0, seg_n}),
    .quo (ph_q), .rem (ph_r)
  );

  // neighbour column (i+1) mod (m+1)
  uvs_div u_div_col (
    .clk (clk), .en (adv),
    .num ({15'd0, {1'b0, in_lon_step} + 9'd1}),
    .den ({1'b0, seg_m} + 9'd1),
    .quo (md_q), .rem (md_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_r[0] <= in_lon_step;
      j_r[0] <= in_lat_step;
      for (int k = 1; k < DIV_STAGES; k++) begin
        i_r[k] <= i_r[k-1];
        j_r[k] <= j_r[k-1];
      end
    end
  end

  assign i_l = i_r[DIV_STAGES-1];
  assign j_l = j_r[DIV_STAGES-1];
  assign row = j_l * ({1'b0, seg_m} + 9'd1);
  assign m1  = {10'd0, seg_m} + 18'd1;
  assign cur = {1'b0, row} + {10'd0, i_l};
  assign nb  = {1'b0, row} + {9'd0, md_r};

  always_comb begin
    item            = '0;
    item.theta      = (i_l == seg_m) ? 16'd0 : th_q[15:0];
    item.phi        = ph_q[15:0];
    item.in_range   = (i_l <= seg_m) && (j_l <= seg_n);
    item.quad_valid = (j_l < seg_n);
    if (j_l < seg_n) begin
      item.tri0_a = cur[15:0];
      item.tri0_b = nb[15:0];
      item.tri0_c = 16'(cur + m1);
      item.tri1_a = nb[15:0];
      item.tri1_b = 16'(nb + m1);
      item.tri1_c = 16'(cur + m1);
    end
  end

  // quotient high bits, column quotient and angle remainders carry no information we need
  logic unused_bits;
  assign unused_bits = ^{th_q[DIV_NW-1:16], ph_q[DIV_NW-1:16], md_q, th_r, ph_r};

endmodule

[hw/rtl/uvs_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module uvs_fifo
  import uvs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  uvs_item_t din,
  output logic      full,
  input  logic      pop,
  output uvs_item_t dout,
  output logic      empty
);

  uvs_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, rptr_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full  = (cnt_r == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[hw/rtl/uvs_sine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_sine
// Four-stage quarter-wave polynomial sine, magnitude in Q1.30 plus sign.
// ----------------------------------------------------------------------------
module uvs_sine
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] angle,
  output logic [31:0] mag,
  output logic        neg
);

  logic [14:0] f;
  logic [14:0] f1_r, f2s_r, f3_r;
  logic [28:0] sq1_r, sq2_r;
  logic [27:0] t1_r;
  logic [30:0] tp_r;
  logic        n1_r, n2_r, n3_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic [55:0] p2;
  logic [58:0] p3;
  logic [45:0] p4;

  always_comb begin
    if (angle[14]) f = 15'h4000 - {1'b0, angle[13:0]};
    else           f = {1'b0, angle[13:0]};
  end

  assign p2 = SIN_C * sq1_r;
  assign p3 = (SIN_B - {2'd0, t1_r}) * sq2_r;
  assign p4 = (SIN_A - tp_r) * f3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r  <= f;
      sq1_r <= f * f;
      n1_r  <= angle[15];
      f2s_r <= f1_r;
      sq2_r <= sq1_r;
      t1_r  <= p2[55:28];
      n2_r  <= n1_r;
      f3_r  <= f2s_r;
      tp_r  <= p3[58:28];
      n3_r  <= n2_r;
      mag_r <= p4[45:14];
      neg_r <= n3_r;
    end
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

[hw/rtl/uvs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_back
// Sine/cosine evaluation, vertex products and Q1.15 rounding.
// ----------------------------------------------------------------------------
module uvs_back
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  uvs_item_t   head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [15:0] out_pos_z,
  output uvs_item_t   out_item
);

  function automatic logic [15:0] q15_code(input logic [63:0] m, input int sh,
                                           input logic ng);
    logic [63:0] r;
    logic [15:0] c;
    r = (m + (64'd1 << (sh - 1))) >> sh;
    if (r > CODE_LIM) r = CODE_LIM;
    r = r << CODE_SHIFT;
    c = r[15:0];
    if (ng) c = 16'd0 - c;
    return c;
  endfunction

  logic        adv;
  logic        v_r [BACK_STAGES];
  uvs_item_t   meta_r [BACK_STAGES];
  logic [31:0] ct, st, cp, sp;
  logic        nct, nst, ncp, nsp;
  logic [63:0] px_r, py_r;
  logic [31:0] pz_r;
  logic        nx_r, ny_r, nz_r;
  logic [15:0] x_r, y_r, z_r;

  assign adv = !(v_r[BACK_STAGES-1] && out_stall);
  assign pop = adv && !empty;

  uvs_sine u_cos_t (.clk(clk), .en(adv), .angle(head.theta + 16'h4000), .mag(ct), .neg(nct));
  uvs_sine u_sin_t (.clk(clk), .en(adv), .angle(head.theta),            .mag(st), .neg(nst));
  uvs_sine u_cos_p (.clk(clk), .en(adv), .angle(head.phi + 16'h4000),   .mag(cp), .neg(ncp));
  uvs_sine u_sin_p (.clk(clk), .en(adv), .angle(head.phi),              .mag(sp), .neg(nsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BACK_STAGES; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= !empty;
      for (int k = 1; k < BACK_STAGES; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= head;
      for (int k = 1; k < BACK_STAGES; k++) meta_r[k] <= meta_r[k-1];
      // stage 4: products
      px_r <= ct * sp;
      py_r <= st * sp;
      pz_r <= cp;
      nx_r <= nct ^ nsp;
      ny_r <= nst ^ nsp;
      nz_r <= ncp;
      // stage 5: rounding into output word
      x_r <= q15_code(px_r, SH_XY, nx_r);
      y_r <= q15_code(py_r, SH_XY, ny_r);
      z_r <= q15_code({32'd0, pz_r}, SH_Z, nz_r);
    end
  end

  assign out_valid = v_r[BACK_STAGES-1];
  assign out_pos_x = x_r;
  assign out_pos_y = y_r;
  assign out_pos_z = z_r;
  assign out_item  = meta_r[BACK_STAGES-1];

endmodule

[hw/rtl/uv_sphere_vertex_and_index_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_and_index_gen
// UV sphere grid point to vertex and quad indices.
// From an accepted word to out_valid: 6 divider stages, the queue and
// 6 sine/product/round stages. Throughput: one word per cycle while
// in_stall is low. Synchronous active-low reset empties the pipes and
// queue and sets both segment counts to 20.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_and_index_gen
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_lon_step,
  input  logic [7:0]  in_lat_step,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [15:0] out_pos_z,
  output logic        out_in_range,
  output logic        out_quad_valid,
  output logic [15:0] out_tri0_a,
  output logic [15:0] out_tri0_b,
  output logic [15:0] out_tri0_c,
  output logic [15:0] out_tri1_a,
  output logic [15:0] out_tri1_b,
  output logic [15:0] out_tri1_c
);

  logic [7:0] lon_r, lat_r, seg_m, seg_n;
  logic       push, pop, full, empty;
  uvs_item_t  f_item, head, o_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_r <= LON_RST;
      lat_r <= LAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LON: lon_r <= cfg_data;
        CFG_LAT: lat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign seg_m = (lon_r < 8'd2) ? 8'd2 : ((lon_r > 8'd254) ? 8'd254 : lon_r);
  assign seg_n = (lat_r < 8'd1) ? 8'd1 : ((lat_r > 8'd254) ? 8'd254 : lat_r);

  uvs_front u_front (
    .clk(clk), .rst_n(rst_n), .seg_m(seg_m), .seg_n(seg_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_lon_step(in_lon_step), .in_lat_step(in_lat_step),
    .push(push), .item(f_item), .full(full)
  );

  uvs_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .din(f_item), .full(full),
    .pop(pop), .dout(head), .empty(empty)
  );

  uvs_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .empty(empty), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_item(o_item)
  );

  assign out_in_range   = o_item.in_range;
  assign out_quad_valid = o_item.quad_valid;
  assign out_tri0_a     = o_item.tri0_a;
  assign out_tri0_b     = o_item.tri0_b;
  assign out_tri0_c     = o_item.tri0_c;
  assign out_tri1_a     = o_item.tri1_a;
  assign out_tri1_b     = o_item.tri1_b;
  assign out_tri1_c     = o_item.tri1_c;

endmodule
